[rtl/tepq_pkg.sv]
// ----------------------------------------------------------------------------
// tepq_pkg
// Shared types and constants for the timed event priority queue.
// ----------------------------------------------------------------------------
package tepq_pkg;

    localparam int unsigned TIME_W   = 64;
    localparam int unsigned IDX_W    = 8;
    localparam int unsigned STATUS_W = 2;

    localparam logic [TIME_W-1:0] TIME_NONE = {TIME_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        REQ_SCHEDULE = 1'b0,
        REQ_POP      = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_UP,
        S_POP_LAST,
        S_POP_READ,
        S_POP_CMP,
        S_POP_HEAD,
        S_DONE
    } state_t;

endpackage

[rtl/tepq_if.sv]
// ----------------------------------------------------------------------------
// tepq_req_if / tepq_rsp_if
// Valid/ready channels carrying requests and results of the event queue.
// ----------------------------------------------------------------------------
interface tepq_req_if #(
    parameter int unsigned DATA_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [tepq_pkg::TIME_W-1:0]   event_time;
    logic [tepq_pkg::IDX_W-1:0]    device_index;
    logic [tepq_pkg::IDX_W-1:0]    callback_index;
    logic [DATA_WIDTH-1:0]         event_data;

    modport source (output valid, req_type, event_time, device_index,
                    callback_index, event_data, input ready);
    modport sink   (input valid, req_type, event_time, device_index,
                    callback_index, event_data, output ready);
endinterface

interface tepq_rsp_if #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned COUNT_W    = 7
);
    logic                          valid;
    logic                          ready;
    logic [tepq_pkg::STATUS_W-1:0] status;
    logic [tepq_pkg::TIME_W-1:0]   out_time;
    logic [tepq_pkg::IDX_W-1:0]    out_device;
    logic [tepq_pkg::IDX_W-1:0]    out_callback;
    logic [DATA_WIDTH-1:0]         out_data;
    logic [tepq_pkg::TIME_W-1:0]   next_time;
    logic [COUNT_W-1:0]            pending_count;

    modport source (output valid, status, out_time, out_device, out_callback,
                    out_data, next_time, pending_count, input ready);
    modport sink   (input valid, status, out_time, out_device, out_callback,
                    out_data, next_time, pending_count, output ready);
endinterface

[rtl/tepq_ram.sv]
// ----------------------------------------------------------------------------
// tepq_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module tepq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/timed_event_priority_queue.sv]
// ----------------------------------------------------------------------------
// timed_event_priority_queue
// Earliest-time-first event queue held as a binary min-heap in one RAM.
// ----------------------------------------------------------------------------
// channel | dir | fields
// req     | in  | req_type, event_time, device_index, callback_index, event_data
// rsp     | out | status, out_time, out_device, out_callback, out_data,
//         |     | next_time, pending_count
//
// One transaction at a time. Schedule: sift-up, per heap level a read of the
// parent and a compare/write. Pop: read last entry, then sift-down with the
// children of each level read one after the other through the single RAM
// port, then a head read.
// Ties keep arrival order: each entry's key carries a sequence stamp.
// Reset empties the queue at once; no clearing pass. A stalled result waits
// in the output register and a new request is taken once it is gone.
// ----------------------------------------------------------------------------
module timed_event_priority_queue #(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned DATA_WIDTH  = 32
) (
    input logic clk,
    input logic rst_n,
    tepq_req_if.sink   req,
    tepq_rsp_if.source rsp
);
    localparam int unsigned AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SW  = 32;   // arrival stamp for tie order
    localparam int unsigned TW  = tepq_pkg::TIME_W;
    localparam int unsigned EW  = TW + SW + 2 * tepq_pkg::IDX_W + DATA_WIDTH;

    typedef struct packed {
        logic [TW-1:0]             t;
        logic [SW-1:0]             seq;
        logic [tepq_pkg::IDX_W-1:0] dev;
        logic [tepq_pkg::IDX_W-1:0] cb;
        logic [DATA_WIDTH-1:0]     data;
    } entry_t;

    tepq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [SW-1:0]    seq_reg, seq_next;
    entry_t           cur_reg, cur_next;     // item being sifted
    logic [CW-1:0]    pos_reg, pos_next;     // 1-based heap position
    entry_t           lc_reg, lc_next;       // left child held
    logic [1:0]       sub_reg, sub_next;     // sift-down sub-step
    entry_t           out_reg, out_next;     // popped entry
    tepq_pkg::status_t st_reg, st_next;
    logic [TW-1:0]    nt_reg, nt_next;
    logic             rv_reg, rv_next;

    logic             we;
    logic [AW-1:0]    addr;
    entry_t           wdata, rdata;
    logic [EW-1:0]    rraw;

    tepq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_store (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rraw)
    );
    assign rdata = entry_t'(rraw);

    function automatic logic before_f(input entry_t a, input entry_t b);
        // stamps differ modulo 2^32; order holds while live stamps span under 2^31
        logic [SW-1:0] d;
        d = a.seq - b.seq;
        before_f = (a.t < b.t) || ((a.t == b.t) && d[SW-1]);
    endfunction

    function automatic logic [AW-1:0] a_f(input logic [CW:0] p);
        logic [CW:0] q;
        q = p - 1'b1;
        a_f = q[AW-1:0];
    endfunction

    logic [CW:0] pos_w, lpos, rpos;
    assign pos_w = {1'b0, pos_reg};
    assign lpos  = {pos_w[CW-1:0], 1'b0};
    assign rpos  = {pos_w[CW-1:0], 1'b1};

    assign req.ready = (state_reg == tepq_pkg::S_IDLE) && !rv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tepq_pkg::S_IDLE;
            count_reg <= '0;
            seq_reg   <= '0;
            rv_reg    <= 1'b0;
            nt_reg    <= tepq_pkg::TIME_NONE;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            seq_reg   <= seq_next;
            rv_reg    <= rv_next;
            nt_reg    <= nt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        pos_reg <= pos_next;
        lc_reg  <= lc_next;
        sub_reg <= sub_next;
        out_reg <= out_next;
        st_reg  <= st_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        seq_next   = seq_reg;
        cur_next   = cur_reg;
        pos_next   = pos_reg;
        lc_next    = lc_reg;
        sub_next   = sub_reg;
        out_next   = out_reg;
        st_next    = st_reg;
        nt_next    = nt_reg;
        rv_next    = rv_reg && !rsp.ready;
        we         = 1'b0;
        addr       = '0;
        wdata      = cur_reg;
        unique case (state_reg)
            tepq_pkg::S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    cur_next.t    = req.event_time;
                    cur_next.seq  = seq_reg;
                    cur_next.dev  = req.device_index;
                    cur_next.cb   = req.callback_index;
                    cur_next.data = req.event_data;
                    st_next       = tepq_pkg::ST_OK;
                    out_next      = '0;
                    sub_next      = 2'd0;
                    if (req.req_type == tepq_pkg::REQ_SCHEDULE)
                    begin
                        if (count_reg == CW'(QUEUE_DEPTH))
                        begin
                            st_next    = tepq_pkg::ST_FULL;
                            state_next = tepq_pkg::S_DONE;
                        end
                        else
                        begin
                            seq_next   = seq_reg + 1'b1;
                            pos_next   = count_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                            if (req.event_time < nt_reg)
                            begin
                                nt_next = req.event_time;
                            end
                            // read parent of the new slot
                            addr       = a_f({1'b0, count_reg + 1'b1} >> 1);
                            state_next = tepq_pkg::S_PUSH_UP;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        st_next    = tepq_pkg::ST_EMPTY;
                        state_next = tepq_pkg::S_DONE;
                    end
                    else
                    begin
                        addr       = '0;   // head is read here
                        state_next = tepq_pkg::S_POP_LAST;
                    end
                end
            end
            tepq_pkg::S_PUSH_UP:
            begin
                if (sub_reg == 2'd1)
                begin
                    // last cycle's read hit the written slot; fetch the new parent
                    addr     = a_f(pos_w >> 1);
                    sub_next = 2'd0;
                end
                // rdata = parent of pos_reg
                else if (pos_reg != CW'(1) && before_f(cur_reg, rdata))
                begin
                    we       = 1'b1;
                    addr     = a_f(pos_w);
                    wdata    = rdata;
                    pos_next = pos_reg >> 1;
                    sub_next = 2'd1;
                end
                else
                begin
                    we         = 1'b1;
                    addr       = a_f(pos_w);
                    wdata      = cur_reg;
                    state_next = tepq_pkg::S_DONE;
                end
            end
            tepq_pkg::S_POP_LAST:
            begin
                out_next   = rdata;
                addr       = a_f({1'b0, count_reg});
                count_next = count_reg - 1'b1;
                pos_next   = CW'(1);
                sub_next   = 2'd0;
                state_next = tepq_pkg::S_POP_READ;
            end
            tepq_pkg::S_POP_READ:
            begin
                if (sub_reg == 2'd0)
                begin
                    cur_next = rdata;   // last entry, placed at root
                end
                if (count_reg == '0)
                begin
                    nt_next    = tepq_pkg::TIME_NONE;
                    state_next = tepq_pkg::S_DONE;
                end
                else if (lpos > {1'b0, count_reg})
                begin
                    we         = 1'b1;
                    addr       = a_f(pos_w);
                    wdata      = (sub_reg == 2'd0) ? rdata : cur_reg;
                    state_next = tepq_pkg::S_POP_HEAD;
                end
                else
                begin
                    addr       = a_f(lpos);
                    state_next = tepq_pkg::S_POP_CMP;
                    sub_next   = 2'd1;
                end
            end
            tepq_pkg::S_POP_CMP:
            begin
                if (sub_reg == 2'd1)
                begin
                    lc_next = rdata;
                    if (rpos <= {1'b0, count_reg})
                    begin
                        addr     = a_f(rpos);
                        sub_next = 2'd2;
                    end
                    else
                    begin
                        sub_next = 2'd3;
                    end
                end
                else
                begin
                    if (sub_reg == 2'd2 && before_f(rdata, lc_reg))
                    begin
                        if (before_f(rdata, cur_reg))
                        begin
                            we       = 1'b1;
                            addr     = a_f(pos_w);
                            wdata    = rdata;
                            pos_next = rpos[CW-1:0];
                            sub_next = 2'd1;
                            state_next = tepq_pkg::S_POP_READ;
                        end
                        else
                        begin
                            we         = 1'b1;
                            addr       = a_f(pos_w);
                            wdata      = cur_reg;
                            state_next = tepq_pkg::S_POP_HEAD;
                        end
                    end
                    else if (before_f(lc_reg, cur_reg))
                    begin
                        we       = 1'b1;
                        addr     = a_f(pos_w);
                        wdata    = lc_reg;
                        pos_next = lpos[CW-1:0];
                        sub_next = 2'd1;
                        state_next = tepq_pkg::S_POP_READ;
                    end
                    else
                    begin
                        we         = 1'b1;
                        addr       = a_f(pos_w);
                        wdata      = cur_reg;
                        state_next = tepq_pkg::S_POP_HEAD;
                    end
                end
            end
            tepq_pkg::S_POP_HEAD:
            begin
                // sub-step 1 issues the head read, sub-step 0 takes its data
                if (sub_reg != 2'd0)
                begin
                    addr     = '0;
                    sub_next = 2'd0;
                end
                else
                begin
                    nt_next    = rdata.t;
                    state_next = tepq_pkg::S_DONE;
                end
            end
            tepq_pkg::S_DONE:
            begin
                if (!rv_reg)
                begin
                    rv_next    = 1'b1;
                    state_next = tepq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tepq_pkg::S_IDLE;
            end
        endcase
        // head read is issued only after the final write
        if (state_reg != tepq_pkg::S_POP_HEAD && state_next == tepq_pkg::S_POP_HEAD)
        begin
            sub_next = 2'd1;
        end
    end

    assign rsp.valid         = rv_reg;
    assign rsp.status        = st_reg;
    assign rsp.out_time      = out_reg.t;
    assign rsp.out_device    = out_reg.dev;
    assign rsp.out_callback  = out_reg.cb;
    assign rsp.out_data      = out_reg.data;
    assign rsp.next_time     = nt_reg;
    assign rsp.pending_count = count_reg;
endmodule

[test/tb_timed_event_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_event_priority_queue
// Self-checking bench for the timed event queue: a sorted-list predictor
// models the held events, every result transaction is checked field by field.
// ----------------------------------------------------------------------------
module tb_timed_event_priority_queue;

    localparam int unsigned DEPTH   = 64;
    localparam int unsigned DWIDTH  = 32;
    localparam int unsigned COUNT_W = 7;

    typedef struct packed {
        logic [tepq_pkg::TIME_W-1:0] ev_time;
        logic [tepq_pkg::IDX_W-1:0]  dev;
        logic [tepq_pkg::IDX_W-1:0]  cb;
        logic [DWIDTH-1:0]           data;
    } event_t;

    typedef struct packed {
        tepq_pkg::status_t           status;
        logic [tepq_pkg::TIME_W-1:0] out_time;
        logic [tepq_pkg::IDX_W-1:0]  out_device;
        logic [tepq_pkg::IDX_W-1:0]  out_callback;
        logic [DWIDTH-1:0]           out_data;
        logic [tepq_pkg::TIME_W-1:0] next_time;
        logic [COUNT_W-1:0]          pending_count;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tepq_req_if #(.DATA_WIDTH(DWIDTH)) req_ch ();
    tepq_rsp_if #(.DATA_WIDTH(DWIDTH), .COUNT_W(COUNT_W)) rsp_ch ();

    timed_event_priority_queue #(
        .QUEUE_DEPTH(DEPTH),
        .DATA_WIDTH (DWIDTH)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .rsp  (rsp_ch.source)
    );

    always #1 clk = ~clk;

    // predictor state: events held in departure order
    event_t      held_events[$];
    logic [63:0] earliest;
    outcome_t    expected_outcomes[$];

    int unsigned errors   = 0;
    int unsigned n_sent   = 0;
    int unsigned n_seen   = 0;
    int unsigned n_full   = 0;
    int unsigned n_empty  = 0;
    bit          calm     = 1'b0;   // idling off when set

    // Apply one request to the predictor, queue the outcome it gives.
    task automatic predict_request(input tepq_pkg::req_t kind, input event_t ev);
        outcome_t o;
        int       pos;
        begin
            o = '0;
            o.status = tepq_pkg::ST_OK;
            if (kind == tepq_pkg::REQ_SCHEDULE) begin
                if (held_events.size() >= DEPTH) begin
                    o.status = tepq_pkg::ST_FULL;
                    n_full++;
                end
                else begin
                    // insert after every event whose time is not later
                    pos = held_events.size();
                    while (pos > 0 && held_events[pos-1].ev_time > ev.ev_time)
                        pos--;
                    held_events.insert(pos, ev);
                    if (ev.ev_time < earliest)
                        earliest = ev.ev_time;
                end
            end
            else begin
                if (held_events.size() == 0) begin
                    o.status = tepq_pkg::ST_EMPTY;
                    n_empty++;
                end
                else begin
                    o.out_time     = held_events[0].ev_time;
                    o.out_device   = held_events[0].dev;
                    o.out_callback = held_events[0].cb;
                    o.out_data     = held_events[0].data;
                    void'(held_events.pop_front());
                    earliest = (held_events.size() != 0) ? held_events[0].ev_time
                                                         : tepq_pkg::TIME_NONE;
                end
            end
            o.next_time     = earliest;
            o.pending_count = COUNT_W'(held_events.size());
            expected_outcomes.push_back(o);
        end
    endtask

    // Send one request transaction; the predictor runs at acceptance.
    task automatic send_request(input tepq_pkg::req_t kind, input event_t ev);
        begin
            @(posedge clk);
            while (!calm && $urandom_range(99) < 6)
                @(posedge clk);
            req_ch.valid          <= 1'b1;
            req_ch.req_type       <= kind;
            req_ch.event_time     <= ev.ev_time;
            req_ch.device_index   <= ev.dev;
            req_ch.callback_index <= ev.cb;
            req_ch.event_data     <= ev.data;
            @(posedge clk);
            while (!req_ch.ready)
                @(posedge clk);
            predict_request(kind, ev);
            n_sent++;
            req_ch.valid <= 1'b0;
        end
    endtask

    function automatic event_t random_event(input bit narrow_time);
        event_t ev;
        begin
            ev.ev_time = narrow_time ? 64'($urandom_range(40))
                                     : {$urandom, $urandom};
            ev.dev  = 8'($urandom);
            ev.cb   = 8'($urandom);
            ev.data = $urandom;
            return ev;
        end
    endfunction

    task automatic schedule(input logic [63:0] t, input logic [7:0] d,
                            input logic [7:0] c, input logic [31:0] w);
        event_t ev;
        begin
            ev.ev_time = t;
            ev.dev     = d;
            ev.cb      = c;
            ev.data    = w;
            send_request(tepq_pkg::REQ_SCHEDULE, ev);
        end
    endtask

    task automatic pop_one();
        begin
            send_request(tepq_pkg::REQ_POP, random_event(1'b0));
        end
    endtask

    task automatic wait_drained();
        begin
            while (expected_outcomes.size() != 0)
                @(posedge clk);
        end
    endtask

    // result side: random stalls, then field-wise comparison
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_seen++;
                if (expected_outcomes.size() == 0) begin
                    $error("result transaction with nothing expected");
                    errors++;
                end
                else begin
                    outcome_t e;
                    e = expected_outcomes.pop_front();
                    if (rsp_ch.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, rsp_ch.status);
                        errors++;
                    end
                    if (rsp_ch.out_time !== e.out_time) begin
                        $error("out_time exp %h got %h", e.out_time, rsp_ch.out_time);
                        errors++;
                    end
                    if (rsp_ch.out_device !== e.out_device) begin
                        $error("out_device exp %h got %h", e.out_device, rsp_ch.out_device);
                        errors++;
                    end
                    if (rsp_ch.out_callback !== e.out_callback) begin
                        $error("out_callback exp %h got %h", e.out_callback,
                               rsp_ch.out_callback);
                        errors++;
                    end
                    if (rsp_ch.out_data !== e.out_data) begin
                        $error("out_data exp %h got %h", e.out_data, rsp_ch.out_data);
                        errors++;
                    end
                    if (rsp_ch.next_time !== e.next_time) begin
                        $error("next_time exp %h got %h", e.next_time, rsp_ch.next_time);
                        errors++;
                    end
                    if (rsp_ch.pending_count !== e.pending_count) begin
                        $error("pending_count exp %0d got %0d", e.pending_count,
                               rsp_ch.pending_count);
                        errors++;
                    end
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= 6);
        end
        else begin
            rsp_ch.ready <= 1'b0;
        end
    end

    // ---- test tasks ----

    // empty pop straight after reset, field extremes, ties, all-zero/all-one
    task automatic test_directed();
        begin
            pop_one();
            schedule(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
            schedule(64'd0, 8'h00, 8'h00, 32'h0000_0000);
            schedule(64'd100, 8'h01, 8'h10, 32'hA5A5_A5A5);
            schedule(64'd100, 8'h02, 8'h20, 32'h5A5A_5A5A);   // tie, keeps order
            schedule(64'd100, 8'h03, 8'h30, 32'h1234_5678);
            schedule(64'h8000_0000_0000_0000, 8'h80, 8'h7F, 32'h8000_0001);
            schedule(64'd50, 8'h55, 8'hAA, 32'hDEAD_BEEF);
            repeat (8) pop_one();                             // drains then one empty
            pop_one();
        end
    endtask

    // fill to the limit, overflow, then drain past empty
    task automatic test_full_queue();
        int i;
        begin
            for (i = 0; i < DEPTH; i++)
                send_request(tepq_pkg::REQ_SCHEDULE, random_event(i[0]));
            schedule(64'd1, 8'h11, 8'h22, 32'h3333_3333);
            schedule(64'd2, 8'h44, 8'h55, 32'h6666_6666);
            for (i = 0; i < DEPTH + 2; i++)
                pop_one();
        end
    endtask

    // sender holds off until every outcome is back
    task automatic test_drain_pause();
        int i;
        begin
            for (i = 0; i < 10; i++)
                send_request(tepq_pkg::REQ_SCHEDULE, random_event(1'b1));
            wait_drained();
            for (i = 0; i < 10; i++)
                pop_one();
        end
    endtask

    // mixed random traffic, with occasional bursts towards full or empty
    task automatic test_random(input int unsigned count);
        int unsigned i;
        int unsigned bias;
        begin
            bias = 50;
            for (i = 0; i < count; i++) begin
                if (i % 100 == 0)
                    bias = $urandom_range(20, 80);
                calm = (i >= count / 2) && (i < count / 2 + 150);
                if ($urandom_range(99) < bias)
                    send_request(tepq_pkg::REQ_SCHEDULE,
                                 random_event(1'($urandom_range(1))));
                else
                    pop_one();
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= tepq_pkg::REQ_SCHEDULE;
        req_ch.event_time     <= '0;
        req_ch.device_index   <= '0;
        req_ch.callback_index <= '0;
        req_ch.event_data     <= '0;
        earliest = tepq_pkg::TIME_NONE;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_queue();
        test_drain_pause();
        test_random(950);

        wait_drained();
        repeat (50) @(posedge clk);
        $display("Covered %0d requests, %0d results: %0d full drops, %0d empty pops.",
                 n_sent, n_seen, n_full, n_empty);
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("tb_timed_event_priority_queue OK");
        else
            $display("tb_timed_event_priority_queue NOT OK");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_timed_event_priority_queue NOT OK");
        $finish;
    end

endmodule

[filelist.f]
rtl/tepq_pkg.sv
rtl/tepq_if.sv
rtl/tepq_ram.sv
rtl/timed_event_priority_queue.sv
test/tb_timed_event_priority_queue.sv
